// ===== hdl/tcw_pkg.sv =====
package tcw_pkg;

   // Default screen geometry
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // Field widths of the request and result beats
   localparam int INDEX_W      = 11;
   localparam int CURSOR_POS_W = 11;
   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 32;

   // Command codes
   localparam logic [1:0] CMD_PUT_CHAR   = 2'd0;
   localparam logic [1:0] CMD_CLEAR      = 2'd1;
   localparam logic [1:0] CMD_SET_CURSOR = 2'd2;
   localparam logic [1:0] CMD_READ_CELL  = 2'd3;

   // Character codes
   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_BACKSPACE = 8'h08;

   // Register map (index = paddr[2])
   localparam logic REG_TEXT_ATTR  = 1'b0;
   localparam logic REG_CLEAR_ATTR = 1'b1;

   localparam logic [7:0] TEXT_ATTR_RESET  = 8'h0F;
   localparam logic [7:0] CLEAR_ATTR_RESET = 8'h00;

   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] code;
   } cell_type;

   typedef struct packed {
      logic [7:0] text_attr;
      logic [7:0] clear_attr;
   } attr_cfg_type;

   // Packed with cursor_pos in the lowest bits, as on rsp_tdata
   typedef struct packed {
      logic [7:0]              cell_attr;
      logic [7:0]              cell_char;
      logic [CURSOR_POS_W-1:0] cursor_pos;
   } result_type;

endpackage

// ===== hdl/tcw_screen_ram.sv =====
module tcw_screen_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  tcw_pkg::cell_type    wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output tcw_pkg::cell_type    rd_data
);
   import tcw_pkg::*;

   cell_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/tcw_csr.sv =====
module tcw_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output tcw_pkg::attr_cfg_type cfg
);
   import tcw_pkg::*;

   logic [7:0] text_attr_ff;
   logic [7:0] clear_attr_ff;
   logic       wr_stb;

   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff  <= TEXT_ATTR_RESET;
         clear_attr_ff <= CLEAR_ATTR_RESET;
      end else if (wr_stb) begin
         unique case (csr_paddr[2])
            REG_TEXT_ATTR:  text_attr_ff  <= csr_pwdata[7:0];
            REG_CLEAR_ATTR: clear_attr_ff <= csr_pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_TEXT_ATTR:  csr_prdata = {24'd0, text_attr_ff};
         REG_CLEAR_ATTR: csr_prdata = {24'd0, clear_attr_ff};
      endcase
   end

   assign cfg.text_attr  = text_attr_ff;
   assign cfg.clear_attr = clear_attr_ff;

endmodule

// ===== hdl/tcw_engine.sv =====
module tcw_engine #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [7:0]                          req_char,
   input  logic [tcw_pkg::INDEX_W-1:0]         req_index,
   input  tcw_pkg::attr_cfg_type               cfg,
   input  logic                                rsp_free,
   output logic                                rsp_load,
   output tcw_pkg::result_type                 result,
   output logic                                mem_wr_en,
   output logic [$clog2(COLUMNS*ROWS)-1:0]     mem_wr_addr,
   output tcw_pkg::cell_type                   mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(COLUMNS*ROWS)-1:0]     mem_rd_addr,
   input  tcw_pkg::cell_type                   mem_rd_data
);
   import tcw_pkg::*;

   localparam int TOTAL  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(TOTAL);
   localparam int CUR_W  = $clog2(TOTAL + 1);
   localparam int EXT_W  = (CUR_W > INDEX_W) ? CUR_W : INDEX_W;

   localparam logic [CUR_W-1:0] TOTAL_C     = CUR_W'(TOTAL);
   localparam logic [CUR_W-1:0] LAST_CELL_C = CUR_W'(TOTAL - 1);
   localparam logic [CUR_W-1:0] LAST_ROW_C  = CUR_W'(TOTAL - COLUMNS);
   localparam logic [CUR_W-1:0] COLS_C      = CUR_W'(COLUMNS);
   localparam logic [EXT_W-1:0] TOTAL_X     = EXT_W'(TOTAL);
   localparam logic [EXT_W-1:0] LAST_CELL_X = EXT_W'(TOTAL - 1);

   localparam logic [2:0] S_FILL   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_LOCATE = 3'd4;
   localparam logic [2:0] S_SCROLL = 3'd5;
   localparam logic [2:0] S_BLANK  = 3'd6;
   localparam logic [2:0] S_RESP   = 3'd7;

   logic [2:0]         state_ff,     state_in;
   logic               init_ff,      init_in;
   logic [1:0]         cmd_ff,       cmd_in;
   logic [7:0]         char_ff,      char_in;
   logic [INDEX_W-1:0] idx_ff,       idx_in;
   logic [CUR_W-1:0]   cursor_ff,    cursor_in;
   logic [CUR_W-1:0]   rowst_ff,     rowst_in;
   logic [CUR_W-1:0]   ptr_ff,       ptr_in;
   logic [CUR_W-1:0]   tgt_ff,       tgt_in;
   logic [ADDR_W-1:0]  waddr_ff,     waddr_in;
   logic               pend_ff,      pend_in;
   logic [7:0]         fill_attr_ff, fill_attr_in;
   logic [7:0]         rchar_ff,     rchar_in;
   logic [7:0]         rattr_ff,     rattr_in;

   logic [CUR_W-1:0]   row_end;
   logic [CUR_W-1:0]   scroll_dst;
   logic [EXT_W-1:0]   idx_ext;
   logic [EXT_W-1:0]   clamp_ext;
   logic [CUR_W-1:0]   clamp_idx;
   logic [EXT_W-1:0]   cursor_ext;

   logic [CUR_W-1:0]   put_cur;
   logic [CUR_W-1:0]   put_row;
   logic               put_wr;
   logic [CUR_W-1:0]   put_addr;
   logic [7:0]         put_code;

   assign row_end    = rowst_ff + COLS_C;
   assign scroll_dst = ptr_ff - COLS_C;
   assign idx_ext    = EXT_W'(idx_ff);
   assign clamp_ext  = (idx_ext >= TOTAL_X) ? LAST_CELL_X : idx_ext;
   assign clamp_idx  = CUR_W'(clamp_ext);
   assign cursor_ext = EXT_W'(cursor_ff);

   // put-character cursor move and cell write
   always_comb begin
      put_cur  = cursor_ff;
      put_row  = rowst_ff;
      put_wr   = 1'b0;
      put_addr = cursor_ff;
      put_code = BLANK_CHAR;
      priority if (char_ff == CH_NEWLINE) begin
         put_cur = row_end;
         put_row = row_end;
      end else if (char_ff == CH_RETURN) begin
         put_cur = rowst_ff;
      end else if (char_ff == CH_BACKSPACE) begin
         if (cursor_ff != '0) begin
            put_cur = cursor_ff - 1'b1;
            if (cursor_ff == rowst_ff) begin
               put_row = rowst_ff - COLS_C;
            end
         end
         put_wr   = 1'b1;
         put_addr = put_cur;
      end else begin
         put_wr   = 1'b1;
         put_code = char_ff;
         put_cur  = cursor_ff + 1'b1;
         if (put_cur == row_end) begin
            put_row = row_end;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      cmd_in       = cmd_ff;
      char_in      = char_ff;
      idx_in       = idx_ff;
      cursor_in    = cursor_ff;
      rowst_in     = rowst_ff;
      ptr_in       = ptr_ff;
      tgt_in       = tgt_ff;
      waddr_in     = waddr_ff;
      pend_in      = pend_ff;
      fill_attr_in = fill_attr_ff;
      rchar_in     = rchar_ff;
      rattr_in     = rattr_ff;

      req_ready        = 1'b0;
      rsp_load         = 1'b0;
      mem_wr_en        = 1'b0;
      mem_wr_addr      = ptr_ff[ADDR_W-1:0];
      mem_wr_data.attr = cfg.text_attr;
      mem_wr_data.code = BLANK_CHAR;
      mem_rd_en        = 1'b0;
      mem_rd_addr      = ptr_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_FILL: begin
            mem_wr_en        = 1'b1;
            mem_wr_data.attr = fill_attr_ff;
            if (ptr_ff == LAST_CELL_C) begin
               ptr_in   = '0;
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_RESP;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = req_cmd;
               char_in  = req_char;
               idx_in   = req_index;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rchar_in = '0;
            rattr_in = '0;
            unique case (cmd_ff)
               CMD_PUT_CHAR: begin
                  mem_wr_en        = put_wr;
                  mem_wr_addr      = put_addr[ADDR_W-1:0];
                  mem_wr_data.code = put_code;
                  cursor_in        = put_cur;
                  rowst_in         = put_row;
                  if (put_cur == TOTAL_C) begin
                     ptr_in   = COLS_C;
                     pend_in  = 1'b0;
                     state_in = S_SCROLL;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               CMD_CLEAR: begin
                  cursor_in    = '0;
                  rowst_in     = '0;
                  ptr_in       = '0;
                  fill_attr_in = cfg.clear_attr;
                  state_in     = S_FILL;
               end
               CMD_SET_CURSOR: begin
                  tgt_in   = clamp_idx;
                  rowst_in = '0;
                  state_in = S_LOCATE;
               end
               CMD_READ_CELL: begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = clamp_idx[ADDR_W-1:0];
                  state_in    = S_READ;
               end
            endcase
         end
         S_READ: begin
            rchar_in = mem_rd_data.code;
            rattr_in = mem_rd_data.attr;
            state_in = S_RESP;
         end
         S_LOCATE: begin
            if (tgt_ff < row_end) begin
               cursor_in = tgt_ff;
               state_in  = S_RESP;
            end else begin
               rowst_in = row_end;
            end
         end
         S_SCROLL: begin
            // read one row below, write it back in the next cycle
            mem_wr_en   = pend_ff;
            mem_wr_addr = waddr_ff;
            mem_wr_data = mem_rd_data;
            if (ptr_ff != TOTAL_C) begin
               mem_rd_en = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
               pend_in   = 1'b1;
               waddr_in  = scroll_dst[ADDR_W-1:0];
            end else begin
               pend_in  = 1'b0;
               ptr_in   = LAST_ROW_C;
               state_in = S_BLANK;
            end
         end
         S_BLANK: begin
            mem_wr_en = 1'b1;
            if (ptr_ff == LAST_CELL_C) begin
               ptr_in    = '0;
               cursor_in = LAST_ROW_C;
               rowst_in  = LAST_ROW_C;
               state_in  = S_RESP;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         init_ff      <= 1'b1;
         cursor_ff    <= '0;
         rowst_ff     <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         fill_attr_ff <= '0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         cursor_ff    <= cursor_in;
         rowst_ff     <= rowst_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         fill_attr_ff <= fill_attr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      char_ff  <= char_in;
      idx_ff   <= idx_in;
      tgt_ff   <= tgt_in;
      waddr_ff <= waddr_in;
      rchar_ff <= rchar_in;
      rattr_ff <= rattr_in;
   end

   assign result.cursor_pos = cursor_ext[CURSOR_POS_W-1:0];
   assign result.cell_char  = rchar_ff;
   assign result.cell_attr  = rattr_ff;

endmodule

// ===== hdl/text_console_char_writer_unit.sv =====
// Text console: a COLUMNS x ROWS screen of character/attribute cells and a cursor.
//
// req channel: one command per beat. req_tuser carries cmd (put char, clear,
// set cursor, read cell); req_tdata carries char_code and cell_index.
// rsp channel: exactly one beat per command, with the cursor after the
// command and, for read cell, the addressed cell (zero otherwise).
// csr port: text attribute at 0x0, clear attribute at 0x4; write only when idle.
//
// Sequence: the engine works one command at a time. A put char without a scroll
// goes from the exec state to the result state, loads the result register and
// returns to idle for the next command; read cell passes through a read state and
// set cursor through a locate state on the way.
// Set cursor walks down one row per cycle until it reaches the target row. Clear
// sweeps the screen RAM one cell per cycle; a scroll copies every row but the
// top one up through the RAM's single read port and blanks the bottom row.
// Reset: the cursor goes to zero and a clearing pass writes blanks with
// attribute zero; req_tready stays low meanwhile.
// Stall: the result register holds while rsp_tready is low; the engine still
// takes the next command and waits with its result until the register frees.
module text_console_char_writer_unit #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request beat
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tcw_pkg::REQ_TDATA_W-1:0] req_tdata,  // [7:0] char_code, [18:8] cell_index
   input  logic [1:0]                      req_tuser,  // [1:0] cmd
   // result beat
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [10:0] cursor_pos, [18:11] cell_char,
                                                       // [26:19] cell_attr
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import tcw_pkg::*;

   localparam int TOTAL  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(TOTAL);
   localparam int PAD_W  = RSP_TDATA_W - $bits(result_type);

   attr_cfg_type      cfg;
   result_type        result;
   result_type        rsp_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_free;
   logic              rsp_load;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   cell_type          mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   cell_type          mem_rd_data;

   tcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Command sequencer: cursor, clear sweep, scroll copy, cell read
   tcw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_char    (req_tdata[7:0]),
      .req_index   (req_tdata[18:8]),
      .cfg         (cfg),
      .rsp_free    (rsp_free),
      .rsp_load    (rsp_load),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Screen store, one write and one registered read per cycle
   tcw_screen_ram #(
      .DEPTH  (TOTAL),
      .ADDR_W (ADDR_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Result register: free when empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Hold payload until the next load
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_data_ff};

endmodule

// ===== hdl/tcw_checker.sv =====
module tcw_checker #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tcw_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import tcw_pkg::*;

   localparam int TOTAL     = COLUMNS * ROWS;
   localparam int POS_LIMIT = 1 << CURSOR_POS_W;

   // The clearing pass after reset blocks commands
   a_reset_blocks_req: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   // One command at a time: no back-to-back acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while previous one in flight");

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed under stall");

   // Reported cursor always lies on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (TOTAL > POS_LIMIT) ||
                     (int'(rsp_tdata[CURSOR_POS_W-1:0]) < TOTAL))
      else $error("cursor_pos past last cell");

endmodule

bind text_console_char_writer_unit tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import tcw_pkg::*;

   localparam int NUM_CELLS   = COLUMNS_DEFAULT * ROWS_DEFAULT;
   localparam int BOTTOM_ROW  = NUM_CELLS - COLUMNS_DEFAULT;  // first cell of the last row
   localparam int MAX_INDEX   = (1 << INDEX_W) - 1;
   localparam int PHASE_ITEMS = 182;     // at least this many random commands per pressure phase
   localparam int SETTLE      = 16;      // quiet cycles before touching the registers
   localparam int QUIET_LIMIT = 40000;   // covers the reset sweep, a clear or a scroll, stalls

   typedef struct {
      logic [1:0]         op;
      logic [7:0]         code;
      logic [INDEX_W-1:0] position;
   } console_cmd_t;

   // DUT pins; every input starts from a known value
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;  // [7:0] char_code, [18:8] cell_index
   logic [1:0]             req_tuser   = '0;  // [1:0] cmd
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [10:0] cursor_pos, [18:11] cell_char,
                                              // [26:19] cell_attr
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [2:0]             csr_paddr   = '0;
   logic [31:0]            csr_pwdata  = '0;
   logic [31:0]            csr_prdata;
   logic                   csr_pready;

   text_console_char_writer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // Screen shadow: our own copy of the cells, cursor and attributes
   // ------------------------------------------------------------------
   cell_type    screen_shadow [NUM_CELLS];
   int unsigned cursor_shadow;
   logic [7:0]  text_attr_shadow;
   logic [7:0]  clear_attr_shadow;
   int unsigned scroll_count = 0;

   // Stimulus and scoreboard storage
   console_cmd_t pending_cmds [$];
   result_type   awaited_results [$];
   console_cmd_t cmd_on_bus;
   int unsigned  cmd_tally [4] = '{0, 0, 0, 0};
   int unsigned  results_seen = 0;
   int unsigned  mismatches   = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  sender_idle_pct = 0;
   int unsigned  rsp_stall_pct   = 0;

   // Fill every cell with a blank of the given attribute
   function automatic void blank_screen(logic [7:0] attr);
      for (int i = 0; i < NUM_CELLS; i++)
         screen_shadow[i] = {attr, BLANK_CHAR};
   endfunction

   // Apply one command to the shadow and return the result beat it must produce
   function automatic result_type console_step(console_cmd_t c);
      result_type  r;
      int unsigned target;
      r      = '0;
      target = (c.position >= NUM_CELLS) ? NUM_CELLS - 1 : c.position;
      case (c.op)
         CMD_PUT_CHAR: begin
            case (c.code)
               CH_NEWLINE:
                  cursor_shadow = (cursor_shadow / COLUMNS_DEFAULT + 1) * COLUMNS_DEFAULT;
               CH_RETURN:
                  cursor_shadow = (cursor_shadow / COLUMNS_DEFAULT) * COLUMNS_DEFAULT;
               CH_BACKSPACE: begin
                  if (cursor_shadow > 0)
                     cursor_shadow--;
                  screen_shadow[cursor_shadow] = {text_attr_shadow, BLANK_CHAR};
               end
               default: begin
                  screen_shadow[cursor_shadow] = {text_attr_shadow, c.code};
                  cursor_shadow++;
               end
            endcase
            // ran off the end: shift rows up, blank the bottom row, park at its start
            if (cursor_shadow >= NUM_CELLS) begin
               for (int i = 0; i < BOTTOM_ROW; i++)
                  screen_shadow[i] = screen_shadow[i + COLUMNS_DEFAULT];
               for (int i = BOTTOM_ROW; i < NUM_CELLS; i++)
                  screen_shadow[i] = {text_attr_shadow, BLANK_CHAR};
               cursor_shadow = BOTTOM_ROW;
               scroll_count++;
            end
         end
         CMD_CLEAR: begin
            blank_screen(clear_attr_shadow);
            cursor_shadow = 0;
         end
         CMD_SET_CURSOR:
            cursor_shadow = target;
         default: begin
            r.cell_char = screen_shadow[target].code;
            r.cell_attr = screen_shadow[target].attr;
         end
      endcase
      r.cursor_pos = cursor_shadow[CURSOR_POS_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: present the next pending command, predict on accept
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(console_step(cmd_on_bus));
            cmd_tally[cmd_on_bus.op]++;
         end
         // only move on once the current beat is gone; never drop and re-raise valid
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cmd_on_bus.op;
               req_tdata  <= REQ_TDATA_W'({cmd_on_bus.position, cmd_on_bus.code});
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result monitor: compare each accepted beat with the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[$bits(result_type)-1:0]);
            results_seen++;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: cursor %0d char %h attr %h",
                           got.cursor_pos, got.cell_char, got.cell_attr);
            end else begin
               want = awaited_results.pop_front();
               if (got.cursor_pos !== want.cursor_pos || got.cell_char !== want.cell_char ||
                   got.cell_attr !== want.cell_attr) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: cursor exp %0d got %0d, char exp %h got %h, %s %h got %h",
                              results_seen, want.cursor_pos, got.cursor_pos, want.cell_char,
                              got.cell_char, "attr exp", want.cell_attr, got.cell_attr);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves a beat for too long
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no beat moved for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, awaited_results.size());
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void push_cmd(logic [1:0] op, logic [7:0] code,
                                    logic [INDEX_W-1:0] position);
      console_cmd_t c;
      c.op       = op;
      c.code     = code;
      c.position = position;
      pending_cmds.push_back(c);
   endfunction

   // Any byte value, with newline, return and backspace mixed in often
   function automatic logic [7:0] pick_char();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6)  return CH_NEWLINE;
      if (r < 10) return CH_RETURN;
      if (r < 16) return CH_BACKSPACE;
      return 8'($urandom_range(255));
   endfunction

   // Hold until the block has drained every command and result, then settle
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_tvalid || awaited_results.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register write (setup + access), then read it back
   task automatic csr_write(logic reg_sel, logic [7:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);   // write lands here
      if (reg_sel == REG_TEXT_ATTR)
         text_attr_shadow = value;
      else
         clear_attr_shadow = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);   // read data valid in the access cycle
      if (csr_prdata[7:0] !== value) begin
         mismatches++;
         if (mismatches <= 10)
            $display("register at %0d reads %h, wrote %h", {reg_sel, 2'b00},
                     csr_prdata[7:0], value);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Random traffic: mostly position / write / read-back sessions, some clears and noise
   task automatic queue_random_traffic(int budget);
      int          queued;
      int unsigned kind;
      int          anchor;
      int          burst;
      int          reads;
      int          lo;
      int          hi;
      queued = 0;
      while (queued < budget) begin
         kind = $urandom_range(99);
         if (kind < 6) begin
            // noise: any command, any field values
            push_cmd(2'($urandom_range(3)), 8'($urandom_range(255)),
                     INDEX_W'($urandom_range(MAX_INDEX)));
            queued++;
         end else if (kind < 9) begin
            // clear, then probe a few cells
            push_cmd(CMD_CLEAR, 8'($urandom_range(255)), INDEX_W'($urandom_range(MAX_INDEX)));
            reads = $urandom_range(1, 3);
            for (int i = 0; i < reads; i++)
               push_cmd(CMD_READ_CELL, 8'($urandom_range(255)),
                        INDEX_W'($urandom_range(MAX_INDEX)));
            queued += 1 + reads;
         end else begin
            // place the cursor, often close to the end so the writes scroll
            kind = $urandom_range(99);
            if (kind < 25)      anchor = NUM_CELLS - $urandom_range(1, 6);
            else if (kind < 35) anchor = BOTTOM_ROW + $urandom_range(COLUMNS_DEFAULT - 1);
            else if (kind < 42) anchor = $urandom_range(NUM_CELLS, MAX_INDEX);
            else                anchor = $urandom_range(NUM_CELLS - 1);
            push_cmd(CMD_SET_CURSOR, 8'($urandom_range(255)), INDEX_W'(anchor));
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst; i++)
               push_cmd(CMD_PUT_CHAR, pick_char(), INDEX_W'($urandom_range(MAX_INDEX)));
            // read back around the written span, including the row above after a scroll
            lo    = (anchor > 90) ? anchor - 90 : 0;
            hi    = (anchor + burst + 4 < MAX_INDEX) ? anchor + burst + 4 : MAX_INDEX;
            reads = $urandom_range(1, 4);
            for (int i = 0; i < reads; i++)
               push_cmd(CMD_READ_CELL, 8'($urandom_range(255)),
                        INDEX_W'($urandom_range(hi, lo)));
            queued += 1 + burst + reads;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin : sequencer
      int unsigned idle_pct  [4] = '{0, 47, 0, 34};
      int unsigned stall_pct [4] = '{0, 0, 47, 34};
      logic [7:0]  text_vals [4];
      logic [7:0]  clear_vals[4];

      // shadow starts where the block's reset leaves it
      blank_screen(8'h00);
      cursor_shadow     = 0;
      text_attr_shadow  = TEXT_ATTR_RESET;
      clear_attr_shadow = CLEAR_ATTR_RESET;

      text_vals  = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255))};
      clear_vals = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'($urandom_range(255))};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed pass, reset attributes, no idling
      push_cmd(CMD_READ_CELL, 8'h00, '0);                          // reset contents
      push_cmd(CMD_READ_CELL, 8'hFF, INDEX_W'(MAX_INDEX));         // index clamps to last cell
      push_cmd(CMD_PUT_CHAR, 8'h41, '0);
      push_cmd(CMD_PUT_CHAR, 8'hFF, INDEX_W'(MAX_INDEX));
      push_cmd(CMD_PUT_CHAR, 8'h00, '0);                           // zero byte is ordinary
      push_cmd(CMD_PUT_CHAR, CH_BACKSPACE, '0);
      push_cmd(CMD_PUT_CHAR, CH_RETURN, '0);
      push_cmd(CMD_PUT_CHAR, CH_BACKSPACE, '0);                    // stays put at cell zero
      push_cmd(CMD_PUT_CHAR, CH_NEWLINE, '0);
      push_cmd(CMD_READ_CELL, 8'h00, INDEX_W'(1));
      push_cmd(CMD_READ_CELL, 8'h00, INDEX_W'(2));
      push_cmd(CMD_SET_CURSOR, 8'h00, INDEX_W'(NUM_CELLS - 1));
      push_cmd(CMD_PUT_CHAR, 8'h5A, '0);                           // write in last cell scrolls
      push_cmd(CMD_READ_CELL, 8'h00, INDEX_W'(BOTTOM_ROW - 1));
      push_cmd(CMD_READ_CELL, 8'h00, INDEX_W'(BOTTOM_ROW));
      push_cmd(CMD_SET_CURSOR, 8'hFF, INDEX_W'(MAX_INDEX));        // cursor clamps
      push_cmd(CMD_PUT_CHAR, CH_NEWLINE, '0);                      // newline on bottom row scrolls
      push_cmd(CMD_SET_CURSOR, 8'h00, INDEX_W'(NUM_CELLS));
      push_cmd(CMD_PUT_CHAR, CH_RETURN, '0);
      push_cmd(CMD_PUT_CHAR, CH_BACKSPACE, '0);                    // backs into the row above
      push_cmd(CMD_CLEAR, 8'hFF, INDEX_W'(MAX_INDEX));
      push_cmd(CMD_READ_CELL, 8'h00, INDEX_W'(1234));
      push_cmd(CMD_SET_CURSOR, 8'h00, INDEX_W'(1234));
      push_cmd(CMD_PUT_CHAR, CH_NEWLINE, '0);
      push_cmd(CMD_READ_CELL, 8'h00, INDEX_W'(NUM_CELLS - 1));
      wait_drained();

      // Random phases, each with its own attributes and handshake pressure
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(REG_TEXT_ATTR, text_vals[ph]);
         csr_write(REG_CLEAR_ATTR, clear_vals[ph]);
         sender_idle_pct = idle_pct[ph];
         rsp_stall_pct   = stall_pct[ph];
         queue_random_traffic(PHASE_ITEMS);
         wait_drained();
      end

      if (awaited_results.size() != 0)
         $display("%0d predicted results never arrived", awaited_results.size());
      $display("Covered %0d commands: %0d put char, %0d clear, %0d set cursor, %0d read cell",
               cmd_tally[0] + cmd_tally[1] + cmd_tally[2] + cmd_tally[3], cmd_tally[CMD_PUT_CHAR],
               cmd_tally[CMD_CLEAR], cmd_tally[CMD_SET_CURSOR], cmd_tally[CMD_READ_CELL]);
      $display("%0d scrolls over 4 pressure phases and 8 register writes; %0d mismatches",
               scroll_count, mismatches);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
